FILE: rtl/core/histogram_deviation_cluster_finder_defines.svh
// assertion macros shared by the cluster finder modules
`ifndef HISTOGRAM_DEVIATION_CLUSTER_FINDER_DEFINES_SVH
`define HISTOGRAM_DEVIATION_CLUSTER_FINDER_DEFINES_SVH

// property checked on every clock edge outside reset
`define HDCF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define HDCF_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

FILE: rtl/core/hdcf_pkg.sv
`default_nettype none

package hdcf_pkg;

  // parameter defaults
  localparam int unsigned MAX_BINS_DEF   = 4096;
  localparam int unsigned COUNT_BITS_DEF = 24;

  // fixed field widths
  localparam int unsigned MIN_ENTRIES_W = 24;
  localparam int unsigned NSIG_W        = 16;
  localparam int unsigned CLUSTER_W     = 13;
  localparam int unsigned VERDICT_W     = 3;
  localparam int unsigned CFG_IDX_W     = 8;
  localparam int unsigned CFG_DATA_W    = 24;

  // deviation test scales the squared difference by 2^16 (two q8 factors)
  localparam int unsigned LHS_SHIFT = 16;

  // depth of the queue between classifier and run tracker
  localparam int unsigned QUEUE_DEPTH = 4;

  // register reset values
  localparam logic [MIN_ENTRIES_W-1:0] MIN_ENTRIES_RST = 24'd500;
  localparam logic [NSIG_W-1:0]        N_SIGMA_RST     = 16'd768;
  localparam logic [CLUSTER_W-1:0]     MIN_CLUSTER_RST = 13'd2;
  localparam logic [CLUSTER_W-1:0]     RED_CLUSTER_RST = 13'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ENTRIES = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_N_SIGMA     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_CLUSTER = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RED_CLUSTER = 8'd3;

  // verdict codes, zero also marks totals that allow judging
  localparam logic [VERDICT_W-1:0] COND_DEFINED      = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_GREEN     = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_YELLOW    = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_RED       = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_LOW_STATS = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_EMPTY_REF = 3'd4;

  // record kinds
  localparam logic KIND_CLUSTER = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic [MIN_ENTRIES_W-1:0] min_entries;
    logic [NSIG_W-1:0]        n_sigma_q8;
    logic [CLUSTER_W-1:0]     min_cluster_size;
    logic [CLUSTER_W-1:0]     red_cluster_size;
  } hdcf_cfg_t;

  // classified bin handed from front to back
  typedef struct packed {
    logic                 first;
    logic                 last;
    logic [VERDICT_W-1:0] cond;
    logic                 dev;
    logic                 sgn;
  } hdcf_item_t;

endpackage

`default_nettype wire

FILE: rtl/core/hdcf_front.sv
`default_nettype none

module hdcf_front #(
  parameter int unsigned COUNT_BITS = hdcf_pkg::COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  hdcf_pkg::hdcf_cfg_t    cfg,
  input  logic                   bin_valid,
  output logic                   bin_stall,
  input  logic [COUNT_BITS-1:0]  hist_count,
  input  logic [COUNT_BITS-1:0]  ref_count,
  input  logic [COUNT_BITS-1:0]  hist_total,
  input  logic [COUNT_BITS-1:0]  ref_total,
  input  logic                   first_bin,
  input  logic                   last_bin,
  output logic                   q_push,
  output hdcf_pkg::hdcf_item_t   q_item,
  input  logic                   q_full
);

  localparam int unsigned W          = COUNT_BITS;
  localparam int unsigned PW         = 2 * W;
  localparam int unsigned VAR_W      = 3 * W + 1;
  localparam int unsigned VAR_CHUNKS = (VAR_W + W - 1) / W;
  localparam int unsigned SQ_W       = 2 * hdcf_pkg::NSIG_W;
  localparam int unsigned PART_W     = W + SQ_W;
  localparam int unsigned LHS_W      = 2 * PW + hdcf_pkg::LHS_SHIFT;
  localparam int unsigned RHS_W      = VAR_W + SQ_W;
  localparam int unsigned CMP_W      = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int unsigned ME_W       =
    (W > hdcf_pkg::MIN_ENTRIES_W) ? W : hdcf_pkg::MIN_ENTRIES_W;

  typedef enum logic [5:0] {
    F_IDLE = 6'b000001,
    F_MUL1 = 6'b000010,
    F_MUL2 = 6'b000100,
    F_MUL3 = 6'b001000,
    F_MUL4 = 6'b010000,
    F_CMP  = 6'b100000
  } front_state_t;

  front_state_t state, state_next;

  logic accept;
  logic low_stats;
  logic [hdcf_pkg::VERDICT_W-1:0] cond_in;

  // captured word
  logic [W-1:0] h, r, nh, nr;
  logic first, last;
  logic [hdcf_pkg::VERDICT_W-1:0] cond;

  // product chain
  logic [PW-1:0]          a, b, d;
  logic [SQ_W-1:0]        s2;
  logic                   sgn, dnz;
  logic [PW-1:0]          pa_lo, pa_hi, pb_lo, pb_hi;
  logic [PW-1:0]          dll, dlh, dhh;
  logic [VAR_W-1:0]       var_sum;
  logic [VAR_CHUNKS*W-1:0] var_pad;
  logic [PART_W-1:0]      rp [VAR_CHUNKS];
  logic [CMP_W-1:0]       lhs, rhs;
  logic                   dev;

  // handshake: idle, or the compare step frees the unit this cycle
  assign bin_stall = !((state == F_IDLE) || ((state == F_CMP) && !q_full));
  assign accept    = bin_valid && !bin_stall;
  assign q_push    = (state == F_CMP) && !q_full;

  // totals check
  assign low_stats = (ME_W'(hist_total) < ME_W'(cfg.min_entries)) || (hist_total == '0);
  assign cond_in   = low_stats ? hdcf_pkg::VERDICT_LOW_STATS :
                     ((ref_total == '0) ? hdcf_pkg::VERDICT_EMPTY_REF : hdcf_pkg::COND_DEFINED);

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (bin_valid) state_next = F_MUL1;
      F_MUL1:  state_next = F_MUL2;
      F_MUL2:  state_next = F_MUL3;
      F_MUL3:  state_next = F_MUL4;
      F_MUL4:  state_next = F_CMP;
      F_CMP: begin
        if (!q_full) begin
          state_next = bin_valid ? F_MUL1 : F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign var_pad = (VAR_CHUNKS * W)'(var_sum);

  // right side: sum of shifted partial products, then the compare
  always_comb begin
    rhs = '0;
    for (int k = 0; k < VAR_CHUNKS; k++) begin
      rhs = rhs + (CMP_W'(rp[k]) << (k * W));
    end
  end

  assign dev = dnz && (lhs > rhs);

  // datapath, one product level per step
  always_ff @(posedge clk) begin
    if (accept) begin
      h     <= hist_count;
      r     <= ref_count;
      nh    <= hist_total;
      nr    <= ref_total;
      first <= first_bin;
      last  <= last_bin;
      cond  <= cond_in;
    end
    if (state == F_MUL1) begin
      a  <= PW'(h) * PW'(nr);
      b  <= PW'(r) * PW'(nh);
      s2 <= SQ_W'(cfg.n_sigma_q8) * SQ_W'(cfg.n_sigma_q8);
    end
    if (state == F_MUL2) begin
      sgn   <= a > b;
      d     <= (a > b) ? (a - b) : (b - a);
      pa_lo <= PW'(a[W-1:0]) * PW'(nr);
      pa_hi <= PW'(a[PW-1:W]) * PW'(nr);
      pb_lo <= PW'(b[W-1:0]) * PW'(nh);
      pb_hi <= PW'(b[PW-1:W]) * PW'(nh);
    end
    if (state == F_MUL3) begin
      var_sum <= (VAR_W'(pa_hi) << W) + VAR_W'(pa_lo) + (VAR_W'(pb_hi) << W) + VAR_W'(pb_lo);
      dnz     <= d != '0;
      dll     <= PW'(d[W-1:0]) * PW'(d[W-1:0]);
      dlh     <= PW'(d[W-1:0]) * PW'(d[PW-1:W]);
      dhh     <= PW'(d[PW-1:W]) * PW'(d[PW-1:W]);
    end
    if (state == F_MUL4) begin
      lhs <= ((CMP_W'(dhh) << PW) + (CMP_W'(dlh) << (W + 1)) + CMP_W'(dll))
             << hdcf_pkg::LHS_SHIFT;
      for (int k = 0; k < VAR_CHUNKS; k++) begin
        rp[k] <= PART_W'(var_pad[k*W +: W]) * PART_W'(s2);
      end
    end
  end

  // classified word to the queue
  always_comb begin
    q_item.first = first;
    q_item.last  = last;
    q_item.cond  = cond;
    q_item.dev   = dev;
    q_item.sgn   = sgn;
  end

endmodule

`default_nettype wire

FILE: rtl/core/hdcf_queue.sv
`default_nettype none

module hdcf_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  hdcf_pkg::hdcf_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output hdcf_pkg::hdcf_item_t pop_item,
  output logic                 empty
);

`include "histogram_deviation_cluster_finder_defines.svh"

  localparam int unsigned DEPTH = hdcf_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  hdcf_pkg::hdcf_item_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign pop_item = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  `HDCF_ASSERT_NEVER(a_push_when_full, push && full, "queue written while full")
  `HDCF_ASSERT_NEVER(a_pop_when_empty, pop && empty, "queue read while empty")
  `HDCF_ASSERT_RST(a_count_grows, (push && !pop) |=> (count == $past(count) + 1'b1), "queue count lost a word")

endmodule

`default_nettype wire

FILE: rtl/core/hdcf_back.sv
`default_nettype none

module hdcf_back #(
  parameter int unsigned MAX_BINS = hdcf_pkg::MAX_BINS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  hdcf_pkg::hdcf_cfg_t                 cfg,
  input  logic                                q_empty,
  input  hdcf_pkg::hdcf_item_t                q_item,
  output logic                                q_pop,
  output logic                                rec_valid,
  input  logic                                rec_stall,
  output logic                                kind,
  output logic [hdcf_pkg::CLUSTER_W-1:0]      run_length,
  output logic [hdcf_pkg::CLUSTER_W-1:0]      start_at,
  output logic [hdcf_pkg::CLUSTER_W-1:0]      end_at,
  output logic [hdcf_pkg::CLUSTER_W-1:0]      clusters_found,
  output logic [hdcf_pkg::VERDICT_W-1:0]      verdict,
  output logic                                final_res
);

`include "histogram_deviation_cluster_finder_defines.svh"

  localparam int unsigned CNT_W = $clog2(MAX_BINS + 1);
  localparam int unsigned SZ_W  = (CNT_W > hdcf_pkg::CLUSTER_W) ? CNT_W : hdcf_pkg::CLUSTER_W;
  localparam int unsigned FW    = hdcf_pkg::CLUSTER_W;
  localparam int unsigned VW    = hdcf_pkg::VERDICT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BINS);
  localparam logic [1:0] SEV_MAX = 2'd2;

  typedef enum logic [2:0] {
    BK_BIN  = 3'b001,
    BK_END  = 3'b010,
    BK_STAT = 3'b100
  } back_state_t;

  back_state_t state, state_next;

  // histogram state
  logic [CNT_W-1:0] bin_number, bin_number_next;
  logic             run_open, run_open_next;
  logic [CNT_W-1:0] run_count, run_count_next;
  logic [CNT_W-1:0] run_first, run_first_next;
  logic             previous_sign, previous_sign_next;
  logic [1:0]       severity_score, severity_score_next;
  logic [CNT_W-1:0] cluster_tally, cluster_tally_next;
  logic [VW-1:0]    verdict_hold, verdict_hold_next;

  // record being built
  logic          load;
  logic          kind_next;
  logic [FW-1:0] run_length_next, start_at_next, end_at_next, clusters_found_next;
  logic [VW-1:0] verdict_next;
  logic          final_res_next;

  // state as seen by a bin, after a first-bin clear
  logic [CNT_W-1:0] e_bin, e_count, e_first, e_tally;
  logic             e_open, e_prev;
  logic [1:0]       e_sev;
  logic [VW-1:0]    e_vh, vh;
  logic [CNT_W-1:0] pos, pos_m1, pos_end;
  logic             judge, close_bin, emit_bin, close_end, emit_end, out_free;

  function automatic logic [1:0] sev_after(input logic [1:0] sev, input logic big);
    sev_after = big ? SEV_MAX : ((sev < SEV_MAX) ? sev + 2'd1 : SEV_MAX);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v < CNT_MAX) ? v + 1'b1 : v;
  endfunction

  assign out_free = !rec_valid || !rec_stall;

  assign e_bin   = q_item.first ? '0 : bin_number;
  assign e_open  = q_item.first ? 1'b0 : run_open;
  assign e_count = q_item.first ? '0 : run_count;
  assign e_first = q_item.first ? '0 : run_first;
  assign e_prev  = q_item.first ? 1'b0 : previous_sign;
  assign e_sev   = q_item.first ? 2'd0 : severity_score;
  assign e_tally = q_item.first ? '0 : cluster_tally;
  assign e_vh    = q_item.first ? hdcf_pkg::COND_DEFINED : verdict_hold;

  // one-based positions, saturating
  assign pos     = (e_bin >= CNT_MAX) ? CNT_MAX : e_bin + 1'b1;
  assign pos_m1  = pos - 1'b1;
  assign pos_end = (bin_number >= CNT_MAX) ? CNT_MAX : bin_number + 1'b1;

  // run closing decisions
  assign vh        = (e_vh == hdcf_pkg::COND_DEFINED) ? q_item.cond : e_vh;
  assign judge     = vh == hdcf_pkg::COND_DEFINED;
  assign close_bin = judge && e_open && (!q_item.dev || (q_item.sgn != e_prev));
  assign emit_bin  = close_bin && (SZ_W'(e_count) >= SZ_W'(cfg.min_cluster_size));
  assign close_end = (verdict_hold == hdcf_pkg::COND_DEFINED) && run_open;
  assign emit_end  = close_end && (SZ_W'(run_count) >= SZ_W'(cfg.min_cluster_size));

  // run tracker steps
  always_comb begin
    state_next          = state;
    q_pop               = 1'b0;
    load                = 1'b0;
    bin_number_next     = bin_number;
    run_open_next       = run_open;
    run_count_next      = run_count;
    run_first_next      = run_first;
    previous_sign_next  = previous_sign;
    severity_score_next = severity_score;
    cluster_tally_next  = cluster_tally;
    verdict_hold_next   = verdict_hold;
    kind_next           = hdcf_pkg::KIND_CLUSTER;
    run_length_next     = '0;
    start_at_next       = '0;
    end_at_next         = '0;
    clusters_found_next = '0;
    verdict_next        = hdcf_pkg::VERDICT_GREEN;
    final_res_next      = 1'b0;
    case (state)
      // one bin: close on sign change or quiet bin, extend or open a run
      BK_BIN: begin
        if (!q_empty && out_free) begin
          q_pop               = 1'b1;
          bin_number_next     = q_item.last ? e_bin : sat_inc(e_bin);
          run_open_next       = e_open;
          run_count_next      = e_count;
          run_first_next      = e_first;
          previous_sign_next  = e_prev;
          severity_score_next = e_sev;
          cluster_tally_next  = e_tally;
          verdict_hold_next   = vh;
          if (emit_bin) begin
            load                = 1'b1;
            run_length_next     = FW'(e_count);
            start_at_next       = FW'(e_first);
            end_at_next         = FW'(pos_m1);
            final_res_next      = !q_item.last;
            cluster_tally_next  = sat_inc(e_tally);
            severity_score_next =
              sev_after(e_sev, SZ_W'(e_count) >= SZ_W'(cfg.red_cluster_size));
          end
          if (judge) begin
            if (q_item.dev) begin
              run_open_next      = 1'b1;
              previous_sign_next = q_item.sgn;
              if (e_open && !close_bin) begin
                run_count_next = sat_inc(e_count);
              end else begin
                run_first_next = pos;
                run_count_next = CNT_W'(1);
              end
            end else if (close_bin) begin
              run_open_next = 1'b0;
            end
          end
          if (q_item.last) begin
            state_next = BK_END;
          end
        end
      end
      // end of histogram closes an open run
      BK_END: begin
        if (out_free) begin
          if (emit_end) begin
            load                = 1'b1;
            run_length_next     = FW'(run_count);
            start_at_next       = FW'(run_first);
            end_at_next         = FW'(pos_end);
            cluster_tally_next  = sat_inc(cluster_tally);
            severity_score_next =
              sev_after(severity_score, SZ_W'(run_count) >= SZ_W'(cfg.red_cluster_size));
          end
          if (close_end) begin
            run_open_next = 1'b0;
          end
          state_next = BK_STAT;
        end
      end
      // status word, then a clean slate
      BK_STAT: begin
        if (out_free) begin
          load           = 1'b1;
          kind_next      = hdcf_pkg::KIND_STATUS;
          final_res_next = 1'b1;
          if (verdict_hold != hdcf_pkg::COND_DEFINED) begin
            verdict_next = verdict_hold;
          end else begin
            clusters_found_next = FW'(cluster_tally);
            verdict_next        = VW'(severity_score);
          end
          bin_number_next     = '0;
          run_open_next       = 1'b0;
          run_count_next      = '0;
          run_first_next      = '0;
          previous_sign_next  = 1'b0;
          severity_score_next = 2'd0;
          cluster_tally_next  = '0;
          verdict_hold_next   = hdcf_pkg::COND_DEFINED;
          state_next          = BK_BIN;
        end
      end
      default: state_next = BK_BIN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= BK_BIN;
      bin_number     <= '0;
      run_open       <= 1'b0;
      run_count      <= '0;
      run_first      <= '0;
      previous_sign  <= 1'b0;
      severity_score <= 2'd0;
      cluster_tally  <= '0;
      verdict_hold   <= hdcf_pkg::COND_DEFINED;
      rec_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      bin_number     <= bin_number_next;
      run_open       <= run_open_next;
      run_count      <= run_count_next;
      run_first      <= run_first_next;
      previous_sign  <= previous_sign_next;
      severity_score <= severity_score_next;
      cluster_tally  <= cluster_tally_next;
      verdict_hold   <= verdict_hold_next;
      if (load) begin
        rec_valid <= 1'b1;
      end else if (!rec_stall) begin
        rec_valid <= 1'b0;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (load) begin
      kind           <= kind_next;
      run_length     <= run_length_next;
      start_at       <= start_at_next;
      end_at         <= end_at_next;
      clusters_found <= clusters_found_next;
      verdict        <= verdict_next;
      final_res      <= final_res_next;
    end
  end

  `HDCF_ASSERT_RST(a_status_is_final, (rec_valid && (kind == hdcf_pkg::KIND_STATUS)) |-> final_res, "status word not marked final")
  `HDCF_ASSERT_RST(a_last_goes_end, ((state == BK_BIN) && q_pop && q_item.last) |=> (state == BK_END), "last bin did not reach end step")
  `HDCF_ASSERT_RST(a_clear_after_status, ((state == BK_STAT) && out_free) |=> (!run_open && (cluster_tally == '0) && (bin_number == '0)), "state not cleared after status")

endmodule

`default_nettype wire

FILE: rtl/core/histogram_deviation_cluster_finder.sv
// Histogram deviation cluster finder.
// Bin channel: bin_valid/bin_stall carry one histogram bin per word with its
// reference bin and both entry totals; first_bin and last_bin frame a histogram.
// Record channel: rec_valid/rec_stall return cluster words (kind 0) and one
// status word (kind 1) after the last bin; final_res marks the last word of a bin.
// Config channel: cfg_valid/cfg_ready write register cfg_index with cfg_data;
// cfg_ready is always high, writes belong in idle time only.
// Pacing: one bin at a time, set by the four-step multiply chain
// and the wide compare in the classifier; the next bin is taken in the
// compare cycle of the current one when the queue is not full.
// Record path: a bin goes through the multiply steps, the compare, the queue
// and the run tracker's registered output word; a last bin also passes an end
// step for the end cluster and a status step, absorbed by a 4-word queue.
// Reset: registers return to their defaults, histogram state clears, the
// queue empties and no record is pending.
// A stalled record holds its word; the tracker then stops, the queue fills
// and bin_stall rises.
`default_nettype none

module histogram_deviation_cluster_finder #(
  parameter int unsigned MAX_BINS   = hdcf_pkg::MAX_BINS_DEF,
  parameter int unsigned COUNT_BITS = hdcf_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               bin_valid,
  output logic                               bin_stall,
  input  logic [COUNT_BITS-1:0]              hist_count,
  input  logic [COUNT_BITS-1:0]              ref_count,
  input  logic [COUNT_BITS-1:0]              hist_total,
  input  logic [COUNT_BITS-1:0]              ref_total,
  input  logic                               first_bin,
  input  logic                               last_bin,
  output logic                               rec_valid,
  input  logic                               rec_stall,
  output logic                               kind,
  output logic [hdcf_pkg::CLUSTER_W-1:0]     run_length,
  output logic [hdcf_pkg::CLUSTER_W-1:0]     start_at,
  output logic [hdcf_pkg::CLUSTER_W-1:0]     end_at,
  output logic [hdcf_pkg::CLUSTER_W-1:0]     clusters_found,
  output logic [hdcf_pkg::VERDICT_W-1:0]     verdict,
  output logic                               final_res,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hdcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hdcf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  hdcf_pkg::hdcf_cfg_t  cfg;
  hdcf_pkg::hdcf_item_t push_item, pop_item;
  logic q_push, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_entries      <= hdcf_pkg::MIN_ENTRIES_RST;
      cfg.n_sigma_q8       <= hdcf_pkg::N_SIGMA_RST;
      cfg.min_cluster_size <= hdcf_pkg::MIN_CLUSTER_RST;
      cfg.red_cluster_size <= hdcf_pkg::RED_CLUSTER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hdcf_pkg::REG_MIN_ENTRIES: cfg.min_entries      <= cfg_data[hdcf_pkg::MIN_ENTRIES_W-1:0];
        hdcf_pkg::REG_N_SIGMA:     cfg.n_sigma_q8       <= cfg_data[hdcf_pkg::NSIG_W-1:0];
        hdcf_pkg::REG_MIN_CLUSTER: cfg.min_cluster_size <= cfg_data[hdcf_pkg::CLUSTER_W-1:0];
        hdcf_pkg::REG_RED_CLUSTER: cfg.red_cluster_size <= cfg_data[hdcf_pkg::CLUSTER_W-1:0];
        default: ;
      endcase
    end
  end

  // classifier
  hdcf_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .bin_valid (bin_valid),
    .bin_stall (bin_stall),
    .hist_count(hist_count),
    .ref_count (ref_count),
    .hist_total(hist_total),
    .ref_total (ref_total),
    .first_bin (first_bin),
    .last_bin  (last_bin),
    .q_push    (q_push),
    .q_item    (push_item),
    .q_full    (q_full)
  );

  // decoupling queue
  hdcf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (q_pop),
    .pop_item (pop_item),
    .empty    (q_empty)
  );

  // run tracker and record output
  hdcf_back #(
    .MAX_BINS(MAX_BINS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_item        (pop_item),
    .q_pop         (q_pop),
    .rec_valid     (rec_valid),
    .rec_stall     (rec_stall),
    .kind          (kind),
    .run_length    (run_length),
    .start_at      (start_at),
    .end_at        (end_at),
    .clusters_found(clusters_found),
    .verdict       (verdict),
    .final_res     (final_res)
  );

endmodule

`default_nettype wire
